[rtl/grid_ray_clearance_check_defines.svh]
// assertion macros shared by the ray clearance check rtl
`ifndef GRID_RAY_CLEARANCE_CHECK_DEFINES_SVH
`define GRID_RAY_CLEARANCE_CHECK_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GRC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/grc_pkg.sv]
// shared types and constants of the grid ray clearance check
`default_nettype none

package grc_pkg;

    localparam int MAX_DIM_DEFAULT = 256;

    localparam int COORD_W    = 8;
    localparam int GRID_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GRID_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [GRID_W-1:0]     grid_dim_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam grid_dim_t GRID_DIM_RESET = grid_dim_t'(256);

    localparam cfg_idx_t CFG_GRID_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_GRID_HEIGHT = cfg_idx_t'(1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        grid_dim_t width;
        grid_dim_t height;
    } grid_cfg_t;

    // one classified item on its way from the front to the walker
    typedef struct packed {
        logic   is_query;
        logic   same_cell;
        logic   occ;
        coord_t x0;
        coord_t y0;
        coord_t adx;
        coord_t ady;
        logic   x_neg;
        logic   y_neg;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/grc_if.sv]
// valid/ready channels for input items and ray results
`default_nettype none

interface grc_item_if;
    import grc_pkg::*;

    logic   valid;
    logic   ready;
    logic   opcode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   cell_occupied;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, cell_occupied,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, cell_occupied,
        output ready
    );
endinterface

interface grc_result_if;
    logic valid;
    logic ready;
    logic ray_clear;

    modport source (output valid, ray_clear, input ready);
    modport sink (input valid, ray_clear, output ready);
endinterface

`default_nettype wire

[rtl/grc_front.sv]
// front end: takes items and classifies them into walker commands
`default_nettype none

module grc_front (
    grc_item_if.sink        item,
    input  wire logic       full,
    output logic            push,
    output grc_pkg::cmd_t   cmd
);
    import grc_pkg::*;

    logic x_neg;
    logic y_neg;

    assign x_neg = item.end_x < item.start_x;
    assign y_neg = item.end_y < item.start_y;

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        cmd.is_query  = (item.opcode == OP_QUERY);
        cmd.same_cell = (item.start_x == item.end_x) && (item.start_y == item.end_y);
        cmd.occ       = item.cell_occupied;
        cmd.x0        = item.start_x;
        cmd.y0        = item.start_y;
        cmd.adx       = x_neg ? (item.start_x - item.end_x) : (item.end_x - item.start_x);
        cmd.ady       = y_neg ? (item.start_y - item.end_y) : (item.end_y - item.start_y);
        cmd.x_neg     = x_neg;
        cmd.y_neg     = y_neg;
    end

endmodule

`default_nettype wire

[rtl/grc_fifo.sv]
// short command queue between front end and walker, head visible without a pop
`default_nettype none

module grc_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire grc_pkg::cmd_t push_data,
    input  wire logic          pop,
    output grc_pkg::cmd_t      head,
    output logic               head_valid,
    output logic               full
);
    import grc_pkg::*;

    `include "grid_ray_clearance_check_defines.svh"

    typedef logic [QUEUE_PTR_W-1:0] ptr_t;
    typedef logic [QUEUE_CNT_W-1:0] cnt_t;

    cmd_t slots [QUEUE_DEPTH];
    ptr_t wr_ptr_reg;
    ptr_t wr_ptr_next;
    ptr_t rd_ptr_reg;
    ptr_t rd_ptr_next;
    cnt_t count_reg;
    cnt_t count_next;

    assign head       = slots[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == cnt_t'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `GRC_ASSERT_IMPL(a_no_push_full, push, !full, "push into full queue")
    `GRC_ASSERT_IMPL(a_no_pop_empty, pop, head_valid, "pop from empty queue")
    `GRC_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not follow a lone push")

endmodule

`default_nettype wire

[rtl/grc_walk.sv]
// back end: occupancy map, cell-by-cell ray walker and result register
`default_nettype none

module grc_walk #(
    parameter int MAX_DIM = grc_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire grc_pkg::cmd_t      head,
    input  wire logic               head_valid,
    output logic                    pop,
    input  wire grc_pkg::grid_cfg_t cfg,
    grc_result_if.source            result
);
    import grc_pkg::*;

    `include "grid_ray_clearance_check_defines.svh"

    localparam int CW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int TW    = 2 * COORD_W + 1;

    typedef enum logic {S_IDLE, S_WALK} state_t;
    typedef logic [AW-1:0] addr_t;
    typedef logic [TW-1:0] tcmp_t;

    state_t    state_reg;
    coord_t    cx_reg;
    coord_t    cy_reg;
    coord_t    rx_reg;
    coord_t    ry_reg;
    tcmp_t     ex_reg;
    tcmp_t     ey_reg;
    grid_dim_t adx2_reg;
    grid_dim_t ady2_reg;
    logic      x_neg_reg;
    logic      y_neg_reg;
    logic      pend_reg;
    logic      pend_out_reg;
    logic      out_valid_reg;
    logic      out_clear_reg;
    logic      rdata_reg;

    logic      mem [DEPTH];

    logic      step_x;
    coord_t    cx_next;
    coord_t    cy_next;
    coord_t    rx_next;
    coord_t    ry_next;
    logic      arrive;
    logic      blocked;
    logic      next_outside;
    logic      finish;
    logic      mem_we;
    addr_t     mem_addr;

    function automatic logic in_map(input coord_t v);
        return 32'(v) < MAX_DIM;
    endfunction

    function automatic addr_t cell_addr(input coord_t x, input coord_t y);
        return {CW'(y), CW'(x)};
    endfunction

    // next x boundary strictly earlier than next y boundary: step x, ties go to y
    assign step_x  = ex_reg < ey_reg;
    assign cx_next = !step_x ? cx_reg : (x_neg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1);
    assign cy_next = step_x ? cy_reg : (y_neg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1);
    assign rx_next = step_x ? rx_reg - 1'b1 : rx_reg;
    assign ry_next = step_x ? ry_reg : ry_reg - 1'b1;
    assign arrive  = (rx_next == '0) && (ry_next == '0);

    // cell entered last cycle, its map bit arrives now
    assign blocked = pend_reg && (pend_out_reg || rdata_reg);
    assign finish  = (state_reg == S_WALK) && (blocked || arrive);

    assign next_outside = !(({1'b0, cx_next} < cfg.width) && ({1'b0, cy_next} < cfg.height)
                            && in_map(cx_next) && in_map(cy_next));

    assign pop = (state_reg == S_IDLE) && head_valid && (!head.is_query || !out_valid_reg);

    assign mem_we   = pop && !head.is_query && in_map(head.x0) && in_map(head.y0);
    assign mem_addr = (state_reg == S_IDLE) ? cell_addr(head.x0, head.y0)
                                            : cell_addr(cx_next, cy_next);

    assign result.valid     = out_valid_reg;
    assign result.ray_clear = out_clear_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= head.occ;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            ex_reg        <= '0;
            ey_reg        <= '0;
            adx2_reg      <= '0;
            ady2_reg      <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_out_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_clear_reg <= 1'b0;
        end
        else
        begin
            // a new result is only loaded while the slot is empty
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && head.is_query)
                    begin
                        if (head.same_cell)
                        begin
                            out_valid_reg <= 1'b1;
                            out_clear_reg <= 1'b1;
                        end
                        else
                        begin
                            cx_reg    <= head.x0;
                            cy_reg    <= head.y0;
                            rx_reg    <= head.adx;
                            ry_reg    <= head.ady;
                            ex_reg    <= TW'(head.ady);
                            ey_reg    <= TW'(head.adx);
                            adx2_reg  <= {head.adx, 1'b0};
                            ady2_reg  <= {head.ady, 1'b0};
                            x_neg_reg <= head.x_neg;
                            y_neg_reg <= head.y_neg;
                            pend_reg  <= 1'b0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (finish)
                    begin
                        out_valid_reg <= 1'b1;
                        out_clear_reg <= !blocked;
                        pend_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        cx_reg       <= cx_next;
                        cy_reg       <= cy_next;
                        rx_reg       <= rx_next;
                        ry_reg       <= ry_next;
                        if (step_x)
                        begin
                            ex_reg <= ex_reg + TW'(ady2_reg);
                        end
                        else
                        begin
                            ey_reg <= ey_reg + TW'(adx2_reg);
                        end
                        pend_reg     <= 1'b1;
                        pend_out_reg <= next_outside;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `GRC_ASSERT_IMPL(a_walk_not_done, state_reg == S_WALK, rx_reg != '0 || ry_reg != '0,
        "walking with target already reached")
    `GRC_ASSERT_IMPL(a_x_step_budget, state_reg == S_WALK && step_x, rx_reg != '0,
        "x step beyond target column")
    `GRC_ASSERT_IMPL(a_slot_free_walk, state_reg == S_WALK, !out_valid_reg,
        "result slot occupied during a walk")
    `GRC_ASSERT_NEXT(a_finish_loads, finish, out_valid_reg && state_reg == S_IDLE,
        "finished walk did not load a result")

endmodule

`default_nettype wire

[rtl/grid_ray_clearance_check.sv]
// top level of the grid ray clearance check: config registers, front end, queue, walker
//
//  channel   dir  handshake      payload
//  item      in   valid/ready    opcode start_x start_y end_x end_y cell_occupied
//  result    out  valid/ready    ray_clear
//  cfg       in   cfg_we         cfg_addr cfg_wdata (0 grid_width, 1 grid_height)
//
// a map write is stored as the walker pops it; a query walks the ray cell by cell,
// at most |dx|+|dy| cells, with one map read per cell
// the map is not cleared by reset; grid_width and grid_height reset to 256
// a four-entry queue keeps taking items while the walker is busy, until it is full
// a finished result sits in the output register until transferred; queries wait for it
`default_nettype none

module grid_ray_clearance_check #(
    parameter int MAX_DIM = grc_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    grc_item_if.sink               item,
    grc_result_if.source           result,
    input  wire logic              cfg_we,
    input  wire grc_pkg::cfg_idx_t cfg_addr,
    input  wire grc_pkg::cfg_data_t cfg_wdata
);
    import grc_pkg::*;

    grid_cfg_t cfg_reg;
    cmd_t      push_cmd;
    cmd_t      head;
    logic      push;
    logic      pop;
    logic      head_valid;
    logic      full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= GRID_DIM_RESET;
            cfg_reg.height <= GRID_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_GRID_WIDTH:  cfg_reg.width  <= cfg_wdata;
                CFG_GRID_HEIGHT: cfg_reg.height <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    grc_front u_front (
        .item (item),
        .full (full),
        .push (push),
        .cmd  (push_cmd)
    );

    grc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    grc_walk #(
        .MAX_DIM (MAX_DIM)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cfg        (cfg_reg),
        .result     (result)
    );

endmodule

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for the grid ray clearance check: random map writes and ray queries
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grc_pkg::*;

    typedef struct {
        logic   opcode;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   occ;
    } map_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_addr;
    cfg_data_t cfg_wdata;

    grc_item_if   item_ch ();
    grc_result_if result_ch ();

    grid_ray_clearance_check i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // predictor state, follows what the block has accepted
    bit occ_map [65536];
    int model_w;
    int model_h;
    bit clear_expected [$];

    // stimulus side view of the map, runs ahead of the block
    bit plan_occ [65536];
    bit plan_written [65536];
    int plan_w = 256;
    int plan_h = 256;

    map_cmd_t cmd_queue [$];
    map_cmd_t next_cmd;
    int       items_made = 0;
    int       error_count = 0;
    int       send_gap;
    int       stall_left;
    logic     calm;
    logic     hold_sender;

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(45, 10);
    endfunction

    function automatic void push_write(input int x, input int y, input bit occ);
        map_cmd_t c;
        c.opcode = OP_WRITE;
        c.sx = coord_t'(x);
        c.sy = coord_t'(y);
        c.ex = coord_t'($urandom_range(255));
        c.ey = coord_t'($urandom_range(255));
        c.occ = occ;
        plan_written[y * 256 + x] = 1'b1;
        plan_occ[y * 256 + x] = occ;
        cmd_queue = {cmd_queue, c};
        items_made++;
    endfunction

    // when planning, any map entry the walk would read gets written first
    function automatic bit cell_taken(input int cx, input int cy, input bit planning,
                                      input int density);
        int w;
        int h;
        int idx;
        w = planning ? plan_w : model_w;
        h = planning ? plan_h : model_h;
        if (cx < 0 || cy < 0 || cx >= w || cy >= h || cx >= 256 || cy >= 256)
            return 1'b1;
        idx = cy * 256 + cx;
        if (!planning)
            return occ_map[idx];
        if (!plan_written[idx])
            push_write(cx, cy, $urandom_range(99) < density);
        return plan_occ[idx];
    endfunction

    // exact rational boundary crossing, ties step in y, endpoints never checked
    function automatic bit trace_ray(input int x0, input int y0, input int x1, input int y1,
                                     input bit planning, input int density);
        int adx;
        int ady;
        int sx;
        int sy;
        int kx;
        int ky;
        int cx;
        int cy;
        if (x0 == x1 && y0 == y1)
            return 1'b1;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x1 > x0) ? 1 : ((x1 < x0) ? -1 : 0);
        sy = (y1 > y0) ? 1 : ((y1 < y0) ? -1 : 0);
        kx = 0;
        ky = 0;
        cx = x0;
        cy = y0;
        for (int n = 0; n < adx + ady; n++)
        begin
            if ((2 * kx + 1) * ady < (2 * ky + 1) * adx)
            begin
                cx += sx;
                kx++;
            end
            else
            begin
                cy += sy;
                ky++;
            end
            if (cx == x1 && cy == y1)
                break;
            if ((adx == 0 || 2 * kx + 1 > 2 * adx) && (ady == 0 || 2 * ky + 1 > 2 * ady))
                break;
            if (cell_taken(cx, cy, planning, density))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_query(input int x0, input int y0, input int x1, input int y1,
                                       input int density);
        map_cmd_t c;
        void'(trace_ray(x0, y0, x1, y1, 1'b1, density));
        c.opcode = OP_QUERY;
        c.sx = coord_t'(x0);
        c.sy = coord_t'(y0);
        c.ex = coord_t'(x1);
        c.ey = coord_t'(y1);
        c.occ = logic'($urandom_range(1));
        cmd_queue = {cmd_queue, c};
        items_made++;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    task automatic fill_random(input int budget);
        int first;
        int lim_x;
        int lim_y;
        int x0;
        int y0;
        int x1;
        int y1;
        int k;
        int span;
        int density;
        first = items_made;
        while (items_made - first < budget)
        begin
            if ($urandom_range(99) < 15)
            begin
                push_write($urandom_range(255), $urandom_range(255), bit'($urandom_range(1)));
                continue;
            end
            lim_x = (plan_w < 1) ? 1 : ((plan_w > 256) ? 256 : plan_w);
            lim_y = (plan_h < 1) ? 1 : ((plan_h > 256) ? 256 : plan_h);
            x0 = ($urandom_range(3) != 0) ? $urandom_range(lim_x - 1) : $urandom_range(255);
            y0 = ($urandom_range(3) != 0) ? $urandom_range(lim_y - 1) : $urandom_range(255);
            k = $urandom_range(99);
            span = (k < 55) ? 8 : ((k < 85) ? 40 : 255);
            if (k >= 95)
                span = 1;
            x1 = clamp_coord(x0 - span + int'($urandom_range(2 * span)));
            y1 = clamp_coord(y0 - span + int'($urandom_range(2 * span)));
            k = $urandom_range(2);
            density = (k == 0) ? 4 : ((k == 1) ? 15 : 35);
            push_query(x0, y0, x1, y1, density);
        end
    endtask

    task automatic program_grid(input cfg_data_t w, input cfg_data_t h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GRID_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= CFG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        plan_w = int'(w);
        plan_h = int'(h);
        @(negedge clk);
    endtask

    // trailing writes give no result, so allow the queue and walker to drain
    task automatic wait_idle();
        do @(negedge clk);
        while (cmd_queue.size() != 0 || item_ch.valid || clear_expected.size() != 0);
        repeat (32) @(negedge clk);
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid         <= 1'b0;
            item_ch.opcode        <= OP_WRITE;
            item_ch.start_x       <= '0;
            item_ch.start_y       <= '0;
            item_ch.end_x         <= '0;
            item_ch.end_y         <= '0;
            item_ch.cell_occupied <= 1'b0;
            send_gap              <= 0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (send_gap > 0)
            begin
                item_ch.valid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (hold_sender || cmd_queue.size() == 0)
            begin
                item_ch.valid <= 1'b0;
            end
            else
            begin
                next_cmd = cmd_queue.pop_front();
                item_ch.valid         <= 1'b1;
                item_ch.opcode        <= next_cmd.opcode;
                item_ch.start_x       <= next_cmd.sx;
                item_ch.start_y       <= next_cmd.sy;
                item_ch.end_x         <= next_cmd.ex;
                item_ch.end_y         <= next_cmd.ey;
                item_ch.cell_occupied <= next_cmd.occ;
                send_gap              <= pick_gap();
            end
        end
    end

    // result receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left      <= pick_gap();
        end
    end

    // monitor: predict on each item transfer, check each result transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            model_w = 256;
            model_h = 256;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_GRID_WIDTH)
                    model_w = int'(cfg_wdata);
                else if (cfg_addr == CFG_GRID_HEIGHT)
                    model_h = int'(cfg_wdata);
            end
            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.opcode == OP_WRITE)
                    occ_map[int'(item_ch.start_y) * 256 + int'(item_ch.start_x)] =
                        item_ch.cell_occupied;
                else
                    clear_expected = {clear_expected,
                                      trace_ray(int'(item_ch.start_x), int'(item_ch.start_y),
                                                int'(item_ch.end_x), int'(item_ch.end_y),
                                                1'b0, 0)};
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (clear_expected.size() == 0)
                    flag_mismatch("result transfer with no query outstanding");
                else if (result_ch.ray_clear !== clear_expected[0])
                begin
                    flag_mismatch($sformatf("ray_clear got %b want %b",
                                            result_ch.ray_clear, clear_expected[0]));
                    void'(clear_expected.pop_front());
                end
                else
                    void'(clear_expected.pop_front());
            end
        end
    end

    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_addr              = CFG_GRID_WIDTH;
        cfg_wdata             = '0;
        calm                  = 1'b0;
        hold_sender           = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.opcode        = OP_WRITE;
        item_ch.start_x       = '0;
        item_ch.start_y       = '0;
        item_ch.end_x         = '0;
        item_ch.end_y         = '0;
        item_ch.cell_occupied = 1'b0;
        result_ch.ready       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at reset geometry
        push_write(5, 5, 1'b1);
        push_query(0, 5, 10, 5, 0);
        push_query(0, 0, 0, 0, 0);
        push_query(255, 255, 255, 255, 0);
        push_query(100, 100, 101, 100, 0);
        push_query(100, 100, 100, 99, 0);
        push_query(100, 100, 101, 101, 0);
        push_query(200, 10, 199, 11, 100);
        push_query(0, 0, 255, 255, 0);
        push_write(128, 128, 1'b1);
        push_query(0, 0, 255, 255, 0);
        push_query(255, 255, 0, 0, 3);
        push_query(0, 255, 255, 0, 5);
        push_query(255, 128, 0, 128, 2);
        push_query(17, 0, 18, 255, 3);
        push_query(3, 250, 1, 2, 3);
        wait_idle();

        fill_random(500);
        wait_idle();

        program_grid(9'd1, 9'd256);
        fill_random(60);
        wait_idle();

        calm <= 1'b1;
        program_grid(9'd256, 9'd1);
        fill_random(60);
        wait_idle();

        calm <= 1'b0;
        program_grid(9'd0, 9'd0);
        fill_random(20);
        wait_idle();

        // hold the sender mid-stream until every outstanding query has answered
        program_grid(9'd511, 9'd300);
        fill_random(250);
        do @(negedge clk);
        while (cmd_queue.size() > 120);
        hold_sender <= 1'b1;
        do @(negedge clk);
        while (item_ch.valid || clear_expected.size() != 0);
        repeat ($urandom_range(20, 1)) @(negedge clk);
        hold_sender <= 1'b0;
        wait_idle();

        program_grid(9'd40, 9'd73);
        fill_random(150);
        wait_idle();

        calm <= 1'b1;
        program_grid(9'd256, 9'd256);
        fill_random(60);
        wait_idle();
        calm <= 1'b0;
        fill_random(70);
        wait_idle();

        repeat (64) @(negedge clk);
        if (clear_expected.size() != 0)
            flag_mismatch("query left without a result");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
